// ----- src/bba_pkg.sv -----
package bba_pkg;

  // default geometry
  localparam int unsigned PoolLog2Def = 16;
  localparam int unsigned LeafLog2Def = 6;

  // request kinds
  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;

  // result status codes
  localparam logic [2:0] StatusOk        = 3'd0;
  localparam logic [2:0] StatusZeroSize  = 3'd1;
  localparam logic [2:0] StatusNoMemory  = 3'd2;
  localparam logic [2:0] StatusNotAlloc  = 3'd3;
  localparam logic [2:0] StatusReserved  = 3'd4;

  // request item
  typedef struct packed {
    logic        action;
    logic [16:0] request_bytes;
    logic [15:0] block_offset;
  } in_t;

  // result item
  typedef struct packed {
    logic [15:0] granted_offset;
    logic [4:0]  granted_log2;
    logic [2:0]  status;
  } out_t;

endpackage

// ----- src/bba_ram.sv -----
module bba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/buddy_block_allocator.sv -----
// channel   | direction | signals                               | accepted when
// request   | in        | in_valid_i, in_ready_o, in_data_i     | in_valid_i & in_ready_o
// result    | out       | out_valid_o, out_ready_i, out_data_o  | out_valid_o & out_ready_i
// config    | in        | cfg_we_i, cfg_data_i                  | cfg_we_i
//
// one item at a time; node state (used, split, list links) lives in one node ram
// allocate: find the nearest non-empty depth, split level by level (pop, push right and left
// halves), then pop the final block; free: descend level by level to the block, merge with
// each free buddy, check the last buddy and push the merged block
// after reset and after each config write the node ram is swept over all 2^(levels+1)-1
// nodes (2047 by default), with no item accepted; a waiting result holds the sequencer in its
// done step, a new item is taken while the previous result is still waiting
module buddy_block_allocator #(
  parameter int unsigned POOL_LOG2 = bba_pkg::PoolLog2Def,
  parameter int unsigned LEAF_LOG2 = bba_pkg::LeafLog2Def
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bba_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bba_pkg::out_t  out_data_o,
  input  logic           cfg_we_i,
  input  logic [10:0]    cfg_data_i
);

  localparam int unsigned Levels = POOL_LOG2 - LEAF_LOG2;
  localparam int unsigned Nodes  = (2 ** (Levels + 1)) - 1;
  localparam int unsigned NW     = Levels + 1;
  localparam int unsigned DW     = $clog2(Levels + 1);
  localparam int unsigned WW     = 2 + 2 * NW;
  localparam int unsigned RW     = (Levels + 1 > 11) ? Levels + 1 : 11;
  localparam int unsigned PW     = POOL_LOG2;
  localparam logic [NW-1:0] None = {NW{1'b1}};

  localparam logic [4:0] S_INIT    = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_FIND    = 5'd2;
  localparam logic [4:0] S_SPLIT   = 5'd3;
  localparam logic [4:0] S_POP_WR  = 5'd4;
  localparam logic [4:0] S_PUSH_R  = 5'd5;
  localparam logic [4:0] S_PUSH_L  = 5'd6;
  localparam logic [4:0] S_AOUT    = 5'd7;
  localparam logic [4:0] S_FR_RD   = 5'd8;
  localparam logic [4:0] S_FR_CK   = 5'd9;
  localparam logic [4:0] S_MG      = 5'd10;
  localparam logic [4:0] S_MG_CK   = 5'd11;
  localparam logic [4:0] S_RM1     = 5'd12;
  localparam logic [4:0] S_RM2     = 5'd13;
  localparam logic [4:0] S_UP      = 5'd14;
  localparam logic [4:0] S_PUSH_F  = 5'd15;
  localparam logic [4:0] S_LK_RD   = 5'd16;
  localparam logic [4:0] S_LK_WR   = 5'd17;
  localparam logic [4:0] S_DONE    = 5'd18;

  logic [4:0]    state_q, state_d;
  bba_pkg::out_t res_q, res_d;
  bba_pkg::out_t out_q, out_d;
  logic          out_valid_q, out_valid_d;
  logic [10:0]   reserved_q, reserved_d;
  logic [NW-1:0] head_q [Levels+1];
  logic [NW-1:0] head_d [Levels+1];
  logic [NW-1:0] n_q, n_d;
  logic [DW-1:0] d_q, d_d;
  logic [DW-1:0] t_q, t_d;
  logic [4:0]    e_q, e_d;
  logic [PW-1:0] off_q, off_d;
  logic [PW-1:0] start_q, start_d;
  logic [NW-1:0] nx_q, nx_d;
  logic [NW-1:0] pv_q, pv_d;
  logic          split_sel_q, split_sel_d;
  logic [NW-1:0] lk_addr_q, lk_addr_d;
  logic [NW-1:0] lk_val_q, lk_val_d;
  logic          lk_sel_q, lk_sel_d;
  logic [4:0]    lk_ret_q, lk_ret_d;
  logic [DW-1:0] id_q, id_d;
  logic [NW-1:0] ik_q, ik_d;

  logic          mem_we;
  logic [NW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;
  logic          mem_re;
  logic [NW-1:0] mem_raddr;
  logic [WW-1:0] mem_rdata;

  // node ram: used, split, next, prev
  bba_ram #(
    .WIDTH(WW),
    .DEPTH(Nodes)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // saturated reservation
  logic [RW-1:0] r_ext, r_sat;
  assign r_ext = RW'(reserved_q);
  assign r_sat = (r_ext > (RW'(1) << Levels)) ? (RW'(1) << Levels) : r_ext;

  // list heads after reservation
  logic [NW-1:0] init_head [Levels+1];
  logic [RW:0]   hc;
  always_comb begin
    hc = '0;
    for (int d = 0; d <= Levels; d++) begin
      hc = (({1'b0, r_sat} + ((RW+1)'(1) << (Levels - d))) - (RW+1)'(1)) >> (Levels - d);
      if (d >= 1 && hc[0]) begin
        init_head[d] = ((NW'(1) << d) - NW'(1)) + NW'(hc);
      end else begin
        init_head[d] = None;
      end
    end
    if (r_sat == '0) begin
      init_head[0] = '0;
    end
  end

  // sweep position and flags of the swept node
  logic [NW-1:0] lvl_first, init_addr;
  logic [RW:0]   ic;
  logic          init_used, init_split;
  assign lvl_first  = (NW'(1) << id_q) - NW'(1);
  assign init_addr  = lvl_first + ik_q;
  assign ic         = (({1'b0, r_sat} + ((RW+1)'(1) << (Levels - id_q))) - (RW+1)'(1))
                      >> (Levels - id_q);
  assign init_used  = ((RW+1)'(ik_q) < ic);
  assign init_split = init_used && (id_q != DW'(Levels));

  // size rounding for an allocate
  logic [16:0] req_m1;
  logic [4:0]  msb, e_raw, e_c;
  always_comb begin
    req_m1 = in_data_i.request_bytes - 17'd1;
    msb = '0;
    for (int i = 0; i < 17; i++) begin
      if (req_m1[i]) msb = 5'(i);
    end
    e_raw = (in_data_i.request_bytes <= 17'd1) ? 5'd0 : msb + 5'd1;
    e_c   = (e_raw < 5'(LEAF_LOG2)) ? 5'(LEAF_LOG2) : e_raw;
  end

  // free range checks
  logic [31:0] off32, rlim32, pool32;
  assign off32  = 32'(in_data_i.block_offset);
  assign rlim32 = 32'(r_sat) << LEAF_LOG2;
  assign pool32 = 32'(1) << POOL_LOG2;

  // nearest non-empty depth at or above the target
  logic          found_ok;
  logic [DW-1:0] found_d;
  always_comb begin
    found_ok = 1'b0;
    found_d  = '0;
    for (int d = 0; d <= Levels; d++) begin
      if (DW'(d) <= t_q && head_q[d] != None) begin
        found_ok = 1'b1;
        found_d  = DW'(d);
      end
    end
  end

  // derived addresses
  logic [DW-1:0] dp1;
  logic [NW-1:0] child_l, child_r, buddy, parent, k_off;
  logic [31:0]   goff;
  logic [PW:0]   half;
  assign dp1     = d_q + DW'(1);
  assign child_l = (n_q << 1) + NW'(1);
  assign child_r = (n_q << 1) + NW'(2);
  assign buddy   = n_q[0] ? n_q + NW'(1) : n_q - NW'(1);
  assign parent  = (n_q - NW'(1)) >> 1;
  assign k_off   = n_q - ((NW'(1) << t_q) - NW'(1));
  assign goff    = 32'(k_off) << e_q;
  assign half    = (PW+1)'(1) << (POOL_LOG2 - 1 - d_q);

  // read fields
  logic          rd_used, rd_split;
  logic [NW-1:0] rd_next, rd_prev;
  assign rd_used  = mem_rdata[WW-1];
  assign rd_split = mem_rdata[WW-2];
  assign rd_next  = mem_rdata[2*NW-1:NW];
  assign rd_prev  = mem_rdata[NW-1:0];

  // sequencer
  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    reserved_d  = reserved_q;
    head_d      = head_q;
    n_d         = n_q;
    d_d         = d_q;
    t_d         = t_q;
    e_d         = e_q;
    off_d       = off_q;
    start_d     = start_q;
    nx_d        = nx_q;
    pv_d        = pv_q;
    split_sel_d = split_sel_q;
    lk_addr_d   = lk_addr_q;
    lk_val_d    = lk_val_q;
    lk_sel_d    = lk_sel_q;
    lk_ret_d    = lk_ret_q;
    id_d        = id_q;
    ik_d        = ik_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      // clearing pass with the reservation written in
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_addr;
        mem_wdata = {init_used, init_split, None, None};
        if (id_q == '0 && ik_q == '0) begin
          head_d = init_head;
        end
        if (ik_q == lvl_first) begin
          ik_d = '0;
          if (id_q == DW'(Levels)) begin
            state_d = S_IDLE;
          end else begin
            id_d = id_q + DW'(1);
          end
        end else begin
          ik_d = ik_q + NW'(1);
        end
      end
      // take an item and decode it
      S_IDLE: begin
        if (in_valid_i) begin
          res_d = '0;
          if (in_data_i.action == bba_pkg::ActAlloc) begin
            if (in_data_i.request_bytes == '0) begin
              res_d.status = bba_pkg::StatusZeroSize;
              state_d      = S_DONE;
            end else if (32'(e_c) > POOL_LOG2) begin
              res_d.status = bba_pkg::StatusNoMemory;
              state_d      = S_DONE;
            end else begin
              e_d     = e_c;
              t_d     = DW'(POOL_LOG2 - 32'(e_c));
              state_d = S_FIND;
            end
          end else begin
            if (off32 < rlim32) begin
              res_d.status = bba_pkg::StatusReserved;
              state_d      = S_DONE;
            end else if (off32 >= pool32) begin
              res_d.status = bba_pkg::StatusNotAlloc;
              state_d      = S_DONE;
            end else begin
              off_d   = PW'(in_data_i.block_offset);
              start_d = '0;
              n_d     = '0;
              d_d     = '0;
              state_d = S_FR_RD;
            end
          end
        end
      end
      S_FIND: begin
        if (!found_ok) begin
          res_d.status = bba_pkg::StatusNoMemory;
          state_d      = S_DONE;
        end else begin
          d_d     = found_d;
          state_d = S_SPLIT;
        end
      end
      // pop the head of the current depth
      S_SPLIT: begin
        mem_re      = 1'b1;
        mem_raddr   = head_q[d_q];
        n_d         = head_q[d_q];
        split_sel_d = (d_q < t_q);
        state_d     = S_POP_WR;
      end
      S_POP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = n_q;
        mem_wdata = {1'b1, split_sel_q, mem_rdata[2*NW-1:0]};
        head_d[d_q] = rd_next;
        if (rd_next != None) begin
          lk_addr_d = rd_next;
          lk_val_d  = None;
          lk_sel_d  = 1'b0;
          lk_ret_d  = split_sel_q ? S_PUSH_R : S_AOUT;
          state_d   = S_LK_RD;
        end else begin
          state_d = split_sel_q ? S_PUSH_R : S_AOUT;
        end
      end
      // push right half, then left half
      S_PUSH_R: begin
        mem_we    = 1'b1;
        mem_waddr = child_r;
        mem_wdata = {1'b0, 1'b0, head_q[dp1], None};
        head_d[dp1] = child_r;
        if (head_q[dp1] != None) begin
          lk_addr_d = head_q[dp1];
          lk_val_d  = child_r;
          lk_sel_d  = 1'b0;
          lk_ret_d  = S_PUSH_L;
          state_d   = S_LK_RD;
        end else begin
          state_d = S_PUSH_L;
        end
      end
      S_PUSH_L: begin
        mem_we    = 1'b1;
        mem_waddr = child_l;
        mem_wdata = {1'b0, 1'b0, head_q[dp1], None};
        head_d[dp1] = child_l;
        d_d         = dp1;
        if (head_q[dp1] != None) begin
          lk_addr_d = head_q[dp1];
          lk_val_d  = child_l;
          lk_sel_d  = 1'b0;
          lk_ret_d  = S_SPLIT;
          state_d   = S_LK_RD;
        end else begin
          state_d = S_SPLIT;
        end
      end
      S_AOUT: begin
        res_d.granted_offset = goff[15:0];
        res_d.granted_log2   = e_q;
        res_d.status         = bba_pkg::StatusOk;
        state_d              = S_DONE;
      end
      // descend to the block at the offset
      S_FR_RD: begin
        mem_re    = 1'b1;
        mem_raddr = n_q;
        state_d   = S_FR_CK;
      end
      S_FR_CK: begin
        if (!rd_used) begin
          res_d.status = bba_pkg::StatusNotAlloc;
          state_d      = S_DONE;
        end else if (!rd_split || d_q == DW'(Levels)) begin
          if (rd_split || off_q != start_q) begin
            res_d.status = bba_pkg::StatusNotAlloc;
            state_d      = S_DONE;
          end else begin
            res_d.granted_log2 = 5'(POOL_LOG2 - 32'(d_q));
            res_d.status       = bba_pkg::StatusOk;
            mem_we    = 1'b1;
            mem_waddr = n_q;
            mem_wdata = {1'b0, 1'b0, mem_rdata[2*NW-1:0]};
            state_d   = S_MG;
          end
        end else begin
          if ({1'b0, off_q} >= ({1'b0, start_q} + half)) begin
            start_d = start_q + half[PW-1:0];
            n_d     = child_r;
          end else begin
            n_d = child_l;
          end
          d_d     = dp1;
          state_d = S_FR_RD;
        end
      end
      // merge with a free buddy
      S_MG: begin
        if (d_q == '0) begin
          state_d = S_PUSH_F;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = buddy;
          state_d   = S_MG_CK;
        end
      end
      S_MG_CK: begin
        if (rd_used) begin
          state_d = S_PUSH_F;
        end else begin
          nx_d = rd_next;
          pv_d = rd_prev;
          if (head_q[d_q] == buddy) begin
            head_d[d_q] = rd_next;
          end
          mem_we    = 1'b1;
          mem_waddr = buddy;
          mem_wdata = {1'b0, 1'b0, mem_rdata[2*NW-1:0]};
          state_d   = S_RM1;
        end
      end
      S_RM1: begin
        if (pv_q != None) begin
          lk_addr_d = pv_q;
          lk_val_d  = nx_q;
          lk_sel_d  = 1'b1;
          lk_ret_d  = S_RM2;
          state_d   = S_LK_RD;
        end else begin
          state_d = S_RM2;
        end
      end
      S_RM2: begin
        if (nx_q != None) begin
          lk_addr_d = nx_q;
          lk_val_d  = pv_q;
          lk_sel_d  = 1'b0;
          lk_ret_d  = S_UP;
          state_d   = S_LK_RD;
        end else begin
          state_d = S_UP;
        end
      end
      S_UP: begin
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = {1'b0, 1'b0, None, None};
        n_d       = parent;
        d_d       = d_q - DW'(1);
        state_d   = S_MG;
      end
      // push the merged block
      S_PUSH_F: begin
        mem_we    = 1'b1;
        mem_waddr = n_q;
        mem_wdata = {1'b0, 1'b0, head_q[d_q], None};
        head_d[d_q] = n_q;
        if (head_q[d_q] != None) begin
          lk_addr_d = head_q[d_q];
          lk_val_d  = n_q;
          lk_sel_d  = 1'b0;
          lk_ret_d  = S_DONE;
          state_d   = S_LK_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      // link field read-modify-write
      S_LK_RD: begin
        mem_re    = 1'b1;
        mem_raddr = lk_addr_q;
        state_d   = S_LK_WR;
      end
      S_LK_WR: begin
        mem_we    = 1'b1;
        mem_waddr = lk_addr_q;
        if (lk_sel_q) begin
          mem_wdata = {rd_used, rd_split, lk_val_q, rd_prev};
        end else begin
          mem_wdata = {rd_used, rd_split, rd_next, lk_val_q};
        end
        state_d = lk_ret_q;
      end
      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // config write restarts the pool
    if (cfg_we_i) begin
      reserved_d = cfg_data_i;
      state_d    = S_INIT;
      id_d       = '0;
      ik_d       = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
      reserved_q  <= 11'd1;
      id_q        <= '0;
      ik_q        <= '0;
      lk_ret_q    <= S_IDLE;
      for (int d = 0; d <= Levels; d++) begin
        head_q[d] <= None;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      reserved_q  <= reserved_d;
      id_q        <= id_d;
      ik_q        <= ik_d;
      lk_ret_q    <= lk_ret_d;
      head_q      <= head_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    res_q       <= res_d;
    out_q       <= out_d;
    n_q         <= n_d;
    d_q         <= d_d;
    t_q         <= t_d;
    e_q         <= e_d;
    off_q       <= off_d;
    start_q     <= start_d;
    nx_q        <= nx_d;
    pv_q        <= pv_d;
    split_sel_q <= split_sel_d;
    lk_addr_q   <= lk_addr_d;
    lk_val_q    <= lk_val_d;
    lk_sel_q    <= lk_sel_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
